// ===== hw/rtl/sorted_unique_set_core_assert.svh =====
// Assertion macros used by the checker file of the sorted set core.
`ifndef SORTED_UNIQUE_SET_CORE_ASSERT_SVH
`define SORTED_UNIQUE_SET_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SUS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sus_pkg.sv =====
// Shared types and codes of the sorted set core.
package sus_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_PRESENT = 3'd1;
    localparam logic [2:0] STATUS_ABSENT  = 3'd2;
    localparam logic [2:0] STATUS_FULL    = 3'd3;
    localparam logic [2:0] STATUS_EMPTY   = 3'd4;
    localparam logic [2:0] STATUS_RANK    = 3'd5;

    localparam int MODE_BITS   = 2;
    localparam int INPUT_BITS  = 32;
    localparam int RANK_BITS   = 4;
    localparam int STATUS_BITS = 3;
    localparam int COUNT_BITS  = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

// ===== hw/rtl/sus_ctrl.sv =====
// Controller state machine of the sorted set core.
module sus_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output sus_pkg::ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd.load = start && (state_reg == ST_IDLE);
        cmd.exec = (state_reg == ST_EXEC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/sus_datapath.sv =====
// Compare-and-shift cell row, occupancy counter and result registers.
module sus_datapath #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sus_pkg::ctrl_cmd_t                      cmd,
    input  logic [sus_pkg::MODE_BITS-1:0]           mode,
    input  logic signed [sus_pkg::INPUT_BITS-1:0]   item_value,
    input  logic [sus_pkg::RANK_BITS-1:0]           rank_index,
    output logic [sus_pkg::STATUS_BITS-1:0]         status,
    output logic [sus_pkg::COUNT_BITS-1:0]          entry_count,
    output logic signed [sus_pkg::INPUT_BITS-1:0]   read_value
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int WW    = (VALUE_BITS > sus_pkg::INPUT_BITS) ? VALUE_BITS
                                                              : sus_pkg::INPUT_BITS;
    localparam int RW    = (IDX_W > sus_pkg::RANK_BITS) ? IDX_W : sus_pkg::RANK_BITS;
    localparam int CW    = (RW > CNT_W) ? RW : CNT_W;
    localparam int OW    = (CNT_W > sus_pkg::COUNT_BITS) ? CNT_W : sus_pkg::COUNT_BITS;

    sus_pkg::mode_t                       mode_reg;
    logic signed [VALUE_BITS-1:0]         value_reg;
    logic [sus_pkg::RANK_BITS-1:0]        rank_reg;
    logic [CNT_W-1:0]                     occ_reg;
    logic [CNT_W-1:0]                     occ_next;
    logic signed [VALUE_BITS-1:0]         entry_reg [CAPACITY];
    logic signed [VALUE_BITS-1:0]         ins_val   [CAPACITY];
    logic signed [VALUE_BITS-1:0]         del_val   [CAPACITY];
    logic [CAPACITY-1:0]                  lt_vec;
    logic [CAPACITY-1:0]                  eq_vec;
    logic [sus_pkg::STATUS_BITS-1:0]      status_reg;
    logic [sus_pkg::STATUS_BITS-1:0]      status_next;
    logic [sus_pkg::COUNT_BITS-1:0]       count_reg;
    logic signed [sus_pkg::INPUT_BITS-1:0] rdval_reg;
    logic signed [VALUE_BITS-1:0]         rd_sel;
    logic signed [WW-1:0]                 in_wide;
    logic signed [WW-1:0]                 rd_wide;
    logic [RW-1:0]                        rank_wide;
    logic [OW-1:0]                        occ_wide;
    logic                                 found;
    logic                                 full;
    logic                                 rank_ok;
    logic                                 do_ins;
    logic                                 do_del;

    // The input value is sign-extended, then wrapped to the entry width.
    assign in_wide = WW'(item_value);

    // One cell per entry: compare against the broadcast value and offer the
    // neighbor that an insert or a remove would shift in.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic held;
        assign held      = CNT_W'(g) < occ_reg;
        assign lt_vec[g] = held && (entry_reg[g] < value_reg);
        assign eq_vec[g] = held && (entry_reg[g] == value_reg);
        if (g == 0)
        begin : g_first
            assign ins_val[g] = value_reg;
        end
        else
        begin : g_rest
            assign ins_val[g] = lt_vec[g-1] ? value_reg : entry_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign del_val[g] = entry_reg[g];
        end
        else
        begin : g_inner
            assign del_val[g] = entry_reg[g+1];
        end
    end

    assign found     = |eq_vec;
    assign full      = occ_reg == CNT_W'(CAPACITY);
    assign rank_wide = RW'(rank_reg);
    assign rank_ok   = CW'(rank_reg) < CW'(occ_reg);

    always_comb
    begin
        status_next = sus_pkg::STATUS_OK;
        occ_next    = occ_reg;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        rd_sel      = '0;
        case (mode_reg)
            sus_pkg::MODE_INSERT:
            begin
                if (found)
                begin
                    status_next = sus_pkg::STATUS_PRESENT;
                end
                else if (full)
                begin
                    status_next = sus_pkg::STATUS_FULL;
                end
                else
                begin
                    do_ins   = 1'b1;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            sus_pkg::MODE_REMOVE:
            begin
                if (found)
                begin
                    do_del   = 1'b1;
                    occ_next = occ_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = sus_pkg::STATUS_ABSENT;
                end
            end
            sus_pkg::MODE_CLEAR:
            begin
                if (occ_reg == '0)
                begin
                    status_next = sus_pkg::STATUS_EMPTY;
                end
                occ_next = '0;
            end
            default:
            begin
                if (rank_ok)
                begin
                    rd_sel = entry_reg[rank_wide[IDX_W-1:0]];
                end
                else
                begin
                    status_next = sus_pkg::STATUS_RANK;
                end
            end
        endcase
    end

    assign rd_wide  = WW'(rd_sel);
    assign occ_wide = OW'(occ_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (cmd.exec)
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= sus_pkg::mode_t'(mode);
            value_reg <= in_wide[VALUE_BITS-1:0];
            rank_reg  <= rank_index;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            count_reg  <= occ_wide[sus_pkg::COUNT_BITS-1:0];
            rdval_reg  <= rd_wide[sus_pkg::INPUT_BITS-1:0];
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (do_ins && !lt_vec[i])
                begin
                    entry_reg[i] <= ins_val[i];
                end
                else if (do_del && !lt_vec[i])
                begin
                    entry_reg[i] <= del_val[i];
                end
            end
        end
    end

    assign status      = status_reg;
    assign entry_count = count_reg;
    assign read_value  = rdval_reg;

endmodule

// ===== hw/rtl/sorted_unique_set_core.sv =====
// Top level of the sorted set core: controller plus compare-and-shift datapath.
//
// The core keeps up to CAPACITY distinct signed values in ascending order.
// A transaction enters when start is high at a rising clock edge while busy is
// low; mode, item_value and rank_index are sampled at that edge. Mode selects
// insert, remove, clear or read by rank.
// Every transaction gives exactly one result: done is high for one cycle and
// status, entry_count and read_value are valid in that same cycle. The
// receiver cannot hold results off, so each result is taken when shown.
// The accepting edge latches the request; the next edge runs the
// compare-and-shift step, in which every cell compares its entry against
// the request value at once and the cells from the insert or remove
// position upward shift by one place, and registers the result.
// A new transaction may enter in the cycle in which done is shown.
// Reset empties the set and returns the controller to idle; entry contents
// are not cleared, since nothing beyond the current count is ever read.
module sorted_unique_set_core #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [sus_pkg::MODE_BITS-1:0]         mode,
    input  logic signed [sus_pkg::INPUT_BITS-1:0] item_value,
    input  logic [sus_pkg::RANK_BITS-1:0]         rank_index,
    output logic                                  done,
    output logic [sus_pkg::STATUS_BITS-1:0]       status,
    output logic [sus_pkg::COUNT_BITS-1:0]        entry_count,
    output logic signed [sus_pkg::INPUT_BITS-1:0] read_value
);

    sus_pkg::ctrl_cmd_t cmd;

    // The controller sequences load and execute cycles and drives the strobe.
    sus_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the entries, the count and the result registers.
    sus_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (mode),
        .item_value  (item_value),
        .rank_index  (rank_index),
        .status      (status),
        .entry_count (entry_count),
        .read_value  (read_value)
    );

endmodule

// ===== hw/rtl/sus_checker.sv =====
// Port-level assertion checker of the sorted set core and its bind.
`include "sorted_unique_set_core_assert.svh"

module sus_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic [sus_pkg::STATUS_BITS-1:0]       status,
    input logic signed [sus_pkg::INPUT_BITS-1:0] read_value
);

    // An accepted transaction makes the core busy in the next cycle.
    `SUS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")

    // Every accepted transaction yields its result strobe after the execute state.
    `SUS_ASSERT_NEXT(a_result_time, start && !busy, ##1 done, "result strobe missing")

    // The result is shown only once the core is idle again.
    `SUS_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")

    // A failed transaction carries a zero read value; non-read ones do too, but go unchecked here.
    `SUS_ASSERT_NOW(a_rd_zero, done && (status != sus_pkg::STATUS_OK), read_value == '0,
        "nonzero read value with error status")

endmodule

bind sorted_unique_set_core sus_checker u_sus_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .read_value (read_value)
);

// ===== bench/sorted_unique_set_core_tb.sv =====
// Self-checking testbench of the sorted set core, built around its own ordered-set tracker.
`timescale 1ns / 1ps

module sorted_unique_set_core_tb;

    localparam int SET_DEPTH     = 16;
    localparam int RANDOM_OPS    = 1200;
    // The final stretch of random transactions runs with no gaps at all.
    localparam int CALM_TAIL     = 150;
    // Cycles without any accepted transaction or result before the run is abandoned.
    localparam int QUIET_LIMIT   = 500;
    // Cycles to keep running once every expected result has arrived.
    localparam int SETTLE_CYCLES = 8;

    localparam logic signed [sus_pkg::INPUT_BITS-1:0] MAX_VAL = 32'sh7FFF_FFFF;
    localparam logic signed [sus_pkg::INPUT_BITS-1:0] MIN_VAL = 32'sh8000_0000;

    // One pending command for the core, with the idle gap that precedes it and
    // whether the sender must first wait for every outstanding result.
    typedef struct {
        sus_pkg::mode_t                        op;
        logic signed [sus_pkg::INPUT_BITS-1:0] val;
        logic [sus_pkg::RANK_BITS-1:0]         rank;
        int unsigned                           gap;
        bit                                    drain;
    } set_op_t;

    // The result the core owes for one accepted transaction.
    typedef struct {
        logic [sus_pkg::STATUS_BITS-1:0]       status;
        logic [sus_pkg::COUNT_BITS-1:0]        count;
        logic signed [sus_pkg::INPUT_BITS-1:0] value;
    } outcome_t;

    logic                                  clk        = 1'b0;
    logic                                  rst_n      = 1'b0;
    logic                                  start      = 1'b0;
    sus_pkg::mode_t                        mode       = sus_pkg::MODE_INSERT;
    logic signed [sus_pkg::INPUT_BITS-1:0] item_value = '0;
    logic [sus_pkg::RANK_BITS-1:0]         rank_index = '0;
    logic                                  busy;
    logic                                  done;
    logic [sus_pkg::STATUS_BITS-1:0]       status;
    logic [sus_pkg::COUNT_BITS-1:0]        entry_count;
    logic signed [sus_pkg::INPUT_BITS-1:0] read_value;

    // Tracker of the set as the core should hold it: ascending, distinct values.
    logic signed [sus_pkg::INPUT_BITS-1:0] tracked_set [SET_DEPTH];
    int                                    tracked_count = 0;

    set_op_t     op_queue[$];
    outcome_t    due_outcomes[$];
    // Both counters move with nonblocking updates, so each side reads the
    // other's value as it stood before the edge.
    int unsigned sent_count   = 0;
    int unsigned got_count    = 0;
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_on      = 1'b1;

    sorted_unique_set_core #(
        .CAPACITY   (SET_DEPTH),
        .VALUE_BITS (sus_pkg::INPUT_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .item_value  (item_value),
        .rank_index  (rank_index),
        .done        (done),
        .status      (status),
        .entry_count (entry_count),
        .read_value  (read_value)
    );

    always #10 clk = ~clk;

    // Applies one accepted transaction to the tracked set and queues the result
    // that the core must report for it.
    task automatic track_set_op(input sus_pkg::mode_t op,
                                input logic signed [sus_pkg::INPUT_BITS-1:0] val,
                                input logic [sus_pkg::RANK_BITS-1:0] rank);
        outcome_t res;
        int       pos;
        res.status = sus_pkg::STATUS_OK;
        res.value  = '0;
        pos        = 0;
        // Insert and remove both start from the first entry that is not below the value.
        if (op == sus_pkg::MODE_INSERT || op == sus_pkg::MODE_REMOVE)
        begin
            while (pos < tracked_count && tracked_set[pos] < val)
                pos++;
        end
        case (op)
            sus_pkg::MODE_INSERT:
            begin
                // A duplicate is refused even when the set is full.
                if (pos < tracked_count && tracked_set[pos] == val)
                    res.status = sus_pkg::STATUS_PRESENT;
                else if (tracked_count >= SET_DEPTH)
                    res.status = sus_pkg::STATUS_FULL;
                else
                begin
                    for (int i = tracked_count; i > pos; i--)
                        tracked_set[i] = tracked_set[i - 1];
                    tracked_set[pos] = val;
                    tracked_count++;
                end
            end
            sus_pkg::MODE_REMOVE:
            begin
                // An absent value is refused wherever it would sit, middle included.
                if (pos < tracked_count && tracked_set[pos] == val)
                begin
                    for (int i = pos; i + 1 < tracked_count; i++)
                        tracked_set[i] = tracked_set[i + 1];
                    tracked_count--;
                end
                else
                    res.status = sus_pkg::STATUS_ABSENT;
            end
            sus_pkg::MODE_CLEAR:
            begin
                if (tracked_count == 0)
                    res.status = sus_pkg::STATUS_EMPTY;
                tracked_count = 0;
            end
            default:
            begin
                if (int'(rank) < tracked_count)
                    res.value = tracked_set[rank];
                else
                    res.status = sus_pkg::STATUS_RANK;
            end
        endcase
        res.count = tracked_count[sus_pkg::COUNT_BITS-1:0];
        due_outcomes.push_back(res);
    endtask

    // Queues one command; while gaps are enabled, about one in four commands is
    // preceded by an idle gap.
    task automatic add_op(input sus_pkg::mode_t op,
                          input logic signed [sus_pkg::INPUT_BITS-1:0] val,
                          input logic [sus_pkg::RANK_BITS-1:0] rank, input bit drain);
        set_op_t cmd;
        cmd.op    = op;
        cmd.val   = val;
        cmd.rank  = rank;
        cmd.drain = drain;
        cmd.gap   = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        op_queue.push_back(cmd);
    endtask

    // Driver. At each rising edge it first notes whether the command on the
    // ports was taken (start high, busy low), feeds that transaction to the
    // tracker, and then decides what the ports carry next. Start gets a single
    // nonblocking update per edge, so back-to-back commands keep it high.
    set_op_t     head;
    int unsigned gap_left  = 0;
    bit          gap_armed = 1'b0;
    bit          took;
    bit          drive_start;
    int          in_flight;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took        = start && !busy;
            drive_start = start && !took;
            if (took)
            begin
                track_set_op(mode, item_value, rank_index);
                void'(op_queue.pop_front());
                sent_count <= sent_count + 1;
            end
            in_flight = int'(sent_count) + int'(took) - int'(got_count);
            if (!drive_start && op_queue.size() != 0)
            begin
                head = op_queue[0];
                if (!gap_armed)
                begin
                    gap_left  = head.gap;
                    gap_armed = 1'b1;
                end
                // A draining command holds back until the core owes nothing.
                if (head.drain && in_flight != 0)
                    drive_start = 1'b0;
                else if (gap_left != 0)
                    gap_left--;
                else
                begin
                    mode        <= head.op;
                    item_value  <= head.val;
                    rank_index  <= head.rank;
                    drive_start = 1'b1;
                    gap_armed   = 1'b0;
                end
            end
            start <= drive_start;
        end
    end

    // Monitor. Every cycle with done high carries one result, which must match
    // the oldest outstanding expectation field by field.
    outcome_t want;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_count <= got_count + 1;
            if (due_outcomes.size() == 0)
            begin
                $error("result with no transaction outstanding: status %0d count %0d value %0d",
                       status, entry_count, read_value);
                fail_count++;
            end
            else
            begin
                want = due_outcomes.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           want.count, entry_count);
                    fail_count++;
                end
                if (read_value !== want.value)
                begin
                    $error("read_value mismatch: expected %0d, actual %0d",
                           want.value, read_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a long stretch with neither an accepted transaction nor a
    // result means the core has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL sorted_unique_set_core");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and end of run. The whole command list is built at time zero;
    // the driver only starts consuming it once reset is released.
    initial
    begin
        logic signed [sus_pkg::INPUT_BITS-1:0] value_pool [24];
        logic signed [sus_pkg::INPUT_BITS-1:0] val;
        sus_pkg::mode_t                        op;
        int                                    made;
        int                                    pool_len;
        int                                    span;
        int                                    pick;
        int                                    w_ins;
        int                                    w_rem;
        int                                    w_read;

        // Directed part: corner cases on an empty set first.
        add_op(sus_pkg::MODE_CLEAR, '0, '0, 1'b0);       // clearing an empty set reports empty
        add_op(sus_pkg::MODE_READ, '0, 4'd0, 1'b0);      // any read of an empty set is out of range
        add_op(sus_pkg::MODE_REMOVE, 32'sd5, '0, 1'b0);  // nothing to remove
        add_op(sus_pkg::MODE_INSERT, MAX_VAL, '0, 1'b0);
        add_op(sus_pkg::MODE_INSERT, MIN_VAL, '0, 1'b0);
        add_op(sus_pkg::MODE_INSERT, MAX_VAL, '0, 1'b0); // duplicate
        add_op(sus_pkg::MODE_REMOVE, 32'sd0, '0, 1'b0);  // absent value lying between two entries
        add_op(sus_pkg::MODE_READ, '0, 4'd1, 1'b0);
        add_op(sus_pkg::MODE_READ, '0, 4'd2, 1'b0);      // rank equal to the count
        // Fill to capacity in descending order so that every insert shifts entries.
        for (int i = 0; i < SET_DEPTH - 2; i++)
            add_op(sus_pkg::MODE_INSERT, 32'((SET_DEPTH - 3 - i) * 1000 - 6500), '0, 1'b0);
        add_op(sus_pkg::MODE_INSERT, MIN_VAL, '0, 1'b0); // duplicate while full
        add_op(sus_pkg::MODE_INSERT, 32'sd1, '0, 1'b0);  // new value while full
        add_op(sus_pkg::MODE_READ, '0, 4'd15, 1'b0);     // top rank
        add_op(sus_pkg::MODE_REMOVE, MIN_VAL, '0, 1'b0); // first entry
        add_op(sus_pkg::MODE_REMOVE, MAX_VAL, '0, 1'b0); // last entry
        add_op(sus_pkg::MODE_CLEAR, 32'sh5A5A_A5A5, 4'd9, 1'b0);

        // Random part in episodes. Each episode draws values mostly from a small
        // pool so that duplicates and successful removes are common, and leans
        // toward filling, draining or a balanced mix.
        made = 0;
        while (made < RANDOM_OPS)
        begin
            pool_len = $urandom_range(6, 24);
            for (int i = 0; i < pool_len; i++)
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: value_pool[i] = $urandom;
                    3:       value_pool[i] = int'($urandom_range(0, 64)) - 32;
                    4:       value_pool[i] = MAX_VAL - int'($urandom_range(0, 3));
                    default: value_pool[i] = MIN_VAL + int'($urandom_range(0, 3));
                endcase
            end
            case ($urandom_range(0, 2))
                0:
                begin
                    w_ins = 70; w_rem = 10; w_read = 17;
                end
                1:
                begin
                    w_ins = 25; w_rem = 50; w_read = 22;
                end
                default:
                begin
                    w_ins = 40; w_rem = 30; w_read = 27;
                end
            endcase
            gaps_on = $urandom_range(0, 3) != 0;
            span    = $urandom_range(30, 80);
            for (int n = 0; n < span && made < RANDOM_OPS; n++)
            begin
                if (made >= RANDOM_OPS - CALM_TAIL)
                    gaps_on = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < w_ins)
                    op = sus_pkg::MODE_INSERT;
                else if (pick < w_ins + w_rem)
                    op = sus_pkg::MODE_REMOVE;
                else if (pick < w_ins + w_rem + w_read)
                    op = sus_pkg::MODE_READ;
                else
                    op = sus_pkg::MODE_CLEAR;
                if ($urandom_range(0, 6) == 0)
                    val = $urandom;
                else
                    val = value_pool[$urandom_range(0, pool_len - 1)];
                // The very first random command always waits for the core to go quiet;
                // the calm tail never waits.
                add_op(op, val, 4'($urandom_range(0, 15)),
                       n == 0 && made < RANDOM_OPS - CALM_TAIL &&
                       (made == 0 || $urandom_range(0, 3) == 0));
                made++;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || due_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS sorted_unique_set_core");
        else
            $display("FAIL sorted_unique_set_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sus_pkg.sv
hw/rtl/sus_ctrl.sv
hw/rtl/sus_datapath.sv
hw/rtl/sorted_unique_set_core.sv
hw/rtl/sus_checker.sv
bench/sorted_unique_set_core_tb.sv
